// ===== src/glmt_pkg.sv =====
// ----------------------------------------------------------------------------
// glmt_pkg
// shared constants, types and helpers of the longest-match tokenizer
// ----------------------------------------------------------------------------
package glmt_pkg;

    localparam int DEF_VOCAB_DEPTH     = 1024;
    localparam int DEF_MAX_TOKEN_BYTES = 16;

    localparam int LEN_W   = 5;
    localparam int IDX_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int N_W     = 6;

    localparam logic [7:0] PREFIX_B0 = 8'hC4;
    localparam logic [7:0] PREFIX_B1 = 8'hA0;
    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [7:0] SPACE     = 8'h20;
    localparam logic [7:0] TAB       = 8'h09;
    localparam logic [7:0] CR        = 8'h0D;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEXT = 1'b1;

    typedef struct packed {
        logic           start;
        logic           prefixed;
        logic [N_W-1:0] n;
    } t_scan_ctl;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [LEN_W-1:0] len;
    } t_scan_res;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == SPACE) || ((c >= TAB) && (c <= CR));
    endfunction

endpackage

// ===== src/glmt_vocab_mem.sv =====
// ----------------------------------------------------------------------------
// glmt_vocab_mem
// vocabulary store, one write and one registered read port
// ----------------------------------------------------------------------------
module glmt_vocab_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 133
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/glmt_scan.sv =====
// ----------------------------------------------------------------------------
// glmt_scan
// walks the vocabulary one entry a cycle, keeps the longest prefix match
// ----------------------------------------------------------------------------
module glmt_scan #(
    parameter int VOCAB_DEPTH     = 1024,
    parameter int MAX_TOKEN_BYTES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  glmt_pkg::t_scan_ctl                   i_ctl,
    input  logic [$clog2(VOCAB_DEPTH+1)-1:0]      i_limit,
    input  logic [MAX_TOKEN_BYTES*8-1:0]          i_window,
    output logic [$clog2(VOCAB_DEPTH)-1:0]        o_raddr,
    input  logic [glmt_pkg::LEN_W+MAX_TOKEN_BYTES*8-1:0] i_rdata,
    output glmt_pkg::t_scan_res                   o_res,
    output logic [$clog2(VOCAB_DEPTH)-1:0]        o_best_idx
);
    import glmt_pkg::*;

    localparam int AW = $clog2(VOCAB_DEPTH);
    localparam int CW = $clog2(VOCAB_DEPTH + 1);
    localparam int BW = MAX_TOKEN_BYTES * 8;

    logic          r_busy;
    logic          r_chk;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_chk_idx;
    logic          r_pre;
    logic [N_W-1:0] r_n;
    logic          r_found;
    logic [LEN_W-1:0] r_best_len;
    logic [AW-1:0] r_best_idx;

    logic              w_issue;
    logic [LEN_W-1:0]  w_len;
    logic [BW-1:0]     w_ent;
    logic [BW+15:0]    w_pre_buf;
    logic [7:0]        w_buf_b;
    logic              w_bytes_eq;
    logic              w_hit;
    logic [N_W-1:0]    w_len6;
    logic [N_W-1:0]    w_minlen;

    assign w_issue = r_busy && (r_idx < i_limit);
    assign o_raddr = r_idx[AW-1:0];

    assign w_len     = i_rdata[LEN_W+BW-1 -: LEN_W];
    assign w_ent     = i_rdata[BW-1:0];
    assign w_pre_buf = {i_window, PREFIX_B1, PREFIX_B0};
    assign w_len6    = N_W'(w_len);
    assign w_minlen  = r_pre ? N_W'(3) : N_W'(1);

    always_comb begin
        w_bytes_eq = 1'b1;
        w_buf_b    = '0;
        for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
            w_buf_b = r_pre ? w_pre_buf[8*k +: 8] : i_window[8*k +: 8];
            if ((N_W'(k) < w_len6) && (w_ent[8*k +: 8] != w_buf_b)) begin
                w_bytes_eq = 1'b0;
            end
        end
    end

    assign w_hit = r_chk && (w_len != '0) && (w_len6 >= w_minlen) && (w_len6 <= r_n)
                && (w_len6 <= N_W'(MAX_TOKEN_BYTES)) && w_bytes_eq
                && (w_len > r_best_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_chk      <= 1'b0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_best_len <= '0;
        end else if (i_ctl.start) begin
            r_busy     <= 1'b1;
            r_chk      <= 1'b0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_best_len <= '0;
        end else begin
            r_chk <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (w_hit) begin
                r_found    <= 1'b1;
                r_best_len <= w_len;
            end
            if (o_res.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_pre <= i_ctl.prefixed;
            r_n   <= i_ctl.n;
        end
        r_chk_idx <= r_idx[AW-1:0];
        if (w_hit) begin
            r_best_idx <= r_chk_idx;
        end
    end

    assign o_res.done  = r_busy && !r_chk && !w_issue;
    assign o_res.found = r_found;
    assign o_res.len   = r_best_len;
    assign o_best_idx  = r_best_idx;

endmodule

// ===== src/greedy_longest_match_tokenizer.sv =====
// ----------------------------------------------------------------------------
// greedy_longest_match_tokenizer
// greedy longest-prefix tokenizer over a loaded byte-string vocabulary
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall): a word either loads one vocabulary
// entry (i_action 0) or delivers one text byte (i_action 1). load words leave
// the sequencer idle. a text byte is appended to a 16-byte lookahead window;
// when the window is full one token step runs, and i_text_last flushes the
// window. each token step that does not skip a blank walks entries 0 ..
// min(entry count, depth)-1 in the memory, one entry a cycle; two scans when
// the space-prefixed form misses. a flush runs up to 16 steps. output channel
// (o_out_valid / i_out_stall): one registered word per token, plus one with
// o_token_valid low at end of text if no token is held; a stalled receiver
// holds the sequencer where it is about to hand over the next word. the
// config port sets the entry count and is always ready. reset clears control
// state and the entry count; vocabulary contents are undefined until loaded.
// ----------------------------------------------------------------------------
module greedy_longest_match_tokenizer #(
    parameter int VOCAB_DEPTH     = glmt_pkg::DEF_VOCAB_DEPTH,
    parameter int MAX_TOKEN_BYTES = glmt_pkg::DEF_MAX_TOKEN_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [glmt_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [glmt_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [glmt_pkg::LEN_W-1:0]   i_entry_length,
    input  logic [63:0]                  i_entry_bytes_low,
    input  logic [63:0]                  i_entry_bytes_high,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_text_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [glmt_pkg::IDX_W-1:0]   o_tok_idx,
    output logic                         o_token_valid,
    output logic                         o_run_last,
    output logic                         o_end_of_text
);
    import glmt_pkg::*;

    localparam int AW   = $clog2(VOCAB_DEPTH);
    localparam int CW   = $clog2(VOCAB_DEPTH + 1);
    localparam int BW   = MAX_TOKEN_BYTES * 8;
    localparam int DW   = LEN_W + BW;
    localparam int CNTW = $clog2(MAX_TOKEN_BYTES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_STEP  = 4'd2;
    localparam logic [3:0] ST_SCNL  = 4'd3;
    localparam logic [3:0] ST_SCNP  = 4'd4;
    localparam logic [3:0] ST_SCNB  = 4'd5;
    localparam logic [3:0] ST_TOK   = 4'd6;
    localparam logic [3:0] ST_AFTER = 4'd7;
    localparam logic [3:0] ST_END   = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [SIZE_W-1:0] r_active_cnt;
    logic [BW-1:0]     r_win, n_win;
    logic [CNTW-1:0]   r_count, n_count;
    logic              r_first, n_first;
    logic              r_last, n_last;
    logic              r_pend_v, n_pend_v;
    logic [IDX_W-1:0]  r_pend_id, n_pend_id;
    logic [IDX_W-1:0]  r_new_id, n_new_id;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_tok_idx, n_tok_idx;
    logic              r_token_valid, n_token_valid;
    logic              r_run_last, n_run_last;
    logic              r_eot, n_eot;

    logic              w_accept;
    logic              w_out_free;
    logic              w_we;
    logic [31:0]       w_idx32;
    logic [31:0]       w_lim32;
    logic [CW-1:0]     w_limit;
    logic [AW-1:0]     w_raddr;
    logic [DW-1:0]     w_rdata;
    logic [127:0]      w_ent_all;
    t_scan_ctl         w_ctl;
    t_scan_res         w_res;
    logic [AW-1:0]     w_best_idx;
    logic [31:0]       w_best32;
    logic [IDX_W-1:0]  w_best_id;
    logic [7:0]        w_head;
    logic              w_pop;
    logic [N_W-1:0]    w_pop_amt;
    logic [N_W-1:0]    w_count6;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_idx32   = 32'(i_entry_index);
    assign w_we      = w_accept && (i_action == ACT_LOAD) && (w_idx32 < VOCAB_DEPTH);
    assign w_ent_all = {i_entry_bytes_high, i_entry_bytes_low};
    assign w_lim32   = (32'(r_active_cnt) < VOCAB_DEPTH) ? 32'(r_active_cnt) : VOCAB_DEPTH;
    assign w_limit   = w_lim32[CW-1:0];
    assign w_best32  = 32'(w_best_idx);
    assign w_best_id = w_best32[IDX_W-1:0];
    assign w_head    = r_win[7:0];
    assign w_count6  = N_W'(r_count);

    glmt_vocab_mem #(
        .DEPTH (VOCAB_DEPTH),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx32[AW-1:0]),
        .i_wdata ({i_entry_length, w_ent_all[BW-1:0]}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    glmt_scan #(
        .VOCAB_DEPTH     (VOCAB_DEPTH),
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_limit    (w_limit),
        .i_window   (r_win),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_res      (w_res),
        .o_best_idx (w_best_idx)
    );

    always_comb begin
        n_state       = r_state;
        n_win         = r_win;
        n_count       = r_count;
        n_first       = r_first;
        n_last        = r_last;
        n_pend_v      = r_pend_v;
        n_pend_id     = r_pend_id;
        n_new_id      = r_new_id;
        n_out_valid   = r_out_valid && i_out_stall;
        n_tok_idx     = r_tok_idx;
        n_token_valid = r_token_valid;
        n_run_last    = r_run_last;
        n_eot         = r_eot;
        w_ctl         = '0;
        w_pop         = 1'b0;
        w_pop_amt     = N_W'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_action == ACT_TEXT)) begin
                    for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
                        if (r_count == CNTW'(k)) begin
                            n_win[8*k +: 8] = i_text_byte;
                        end
                    end
                    if (w_count6 < N_W'(MAX_TOKEN_BYTES)) begin
                        n_count = r_count + CNTW'(1);
                    end
                    n_last  = i_text_last;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_last) begin
                    n_state = (r_count != '0) ? ST_STEP : ST_END;
                end else begin
                    n_state = (w_count6 >= N_W'(MAX_TOKEN_BYTES)) ? ST_STEP : ST_IDLE;
                end
            end
            ST_STEP: begin
                if (w_head == NEWLINE) begin
                    w_ctl.start = 1'b1;
                    w_ctl.n     = N_W'(1);
                    n_state     = ST_SCNL;
                end else if (is_blank(w_head)) begin
                    w_pop   = 1'b1;
                    n_state = ST_AFTER;
                end else if (!r_first) begin
                    w_ctl.start    = 1'b1;
                    w_ctl.prefixed = 1'b1;
                    w_ctl.n        = w_count6 + N_W'(2);
                    n_state        = ST_SCNP;
                end else begin
                    w_ctl.start = 1'b1;
                    w_ctl.n     = w_count6;
                    n_state     = ST_SCNB;
                end
            end
            ST_SCNL: begin
                if (w_res.done) begin
                    w_pop    = 1'b1;
                    n_first  = 1'b1;
                    n_new_id = w_best_id;
                    n_state  = w_res.found ? ST_TOK : ST_AFTER;
                end
            end
            ST_SCNP: begin
                if (w_res.done) begin
                    if (w_res.found) begin
                        w_pop     = 1'b1;
                        w_pop_amt = N_W'(w_res.len) - N_W'(2);
                        n_new_id  = w_best_id;
                        n_state   = ST_TOK;
                    end else begin
                        w_ctl.start = 1'b1;
                        w_ctl.n     = w_count6;
                        n_state     = ST_SCNB;
                    end
                end
            end
            ST_SCNB: begin
                if (w_res.done) begin
                    w_pop   = 1'b1;
                    n_first = 1'b0;
                    if (w_res.found) begin
                        w_pop_amt = N_W'(w_res.len);
                        n_new_id  = w_best_id;
                    end else begin
                        n_new_id = '0;
                    end
                    n_state = ST_TOK;
                end
            end
            ST_TOK: begin
                // the held token goes out once a newer one shows it is not the last
                if (!r_pend_v) begin
                    n_pend_v  = 1'b1;
                    n_pend_id = r_new_id;
                    n_state   = ST_AFTER;
                end else if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_tok_idx     = r_pend_id;
                    n_token_valid = 1'b1;
                    n_run_last    = 1'b0;
                    n_eot         = 1'b0;
                    n_pend_id     = r_new_id;
                    n_state       = ST_AFTER;
                end
            end
            ST_AFTER: begin
                n_state = (r_last && (r_count != '0)) ? ST_STEP : ST_END;
            end
            ST_END: begin
                if (!r_last && !r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_tok_idx     = r_pend_v ? r_pend_id : '0;
                    n_token_valid = r_pend_v;
                    n_run_last    = 1'b1;
                    n_eot         = r_last;
                    n_pend_v      = 1'b0;
                    if (r_last) begin
                        n_count = '0;
                        n_first = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_pop) begin
            n_win = r_win >> {w_pop_amt, 3'b000};
            if (w_pop_amt >= w_count6) begin
                n_count = '0;
            end else begin
                n_count = r_count - w_pop_amt[CNTW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active_cnt <= '0;
            r_count      <= '0;
            r_first      <= 1'b1;
            r_pend_v     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_cnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win         <= n_win;
        r_last        <= n_last;
        r_pend_id     <= n_pend_id;
        r_new_id      <= n_new_id;
        r_tok_idx     <= n_tok_idx;
        r_token_valid <= n_token_valid;
        r_run_last    <= n_run_last;
        r_eot         <= n_eot;
    end

    assign o_out_valid   = r_out_valid;
    assign o_tok_idx     = r_tok_idx;
    assign o_token_valid = r_token_valid;
    assign o_run_last    = r_run_last;
    assign o_end_of_text = r_eot;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        N_W'(r_count) <= N_W'(MAX_TOKEN_BYTES))
        else $error("window count above window depth");

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> ((r_state == ST_SCNL) || (r_state == ST_SCNP) || (r_state == ST_SCNB)))
        else $error("scan finished outside a scan state");

    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_text) |-> o_run_last)
        else $error("end of text without run end");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && r_last && w_out_free) |=> (r_count == '0) && r_first)
        else $error("flush left window state behind");

endmodule
